// ===== src/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: item modes,
// character codes, the blank cell and the screen memory request.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// widest cell address over all supported screen sizes
	localparam int ADDR_W = 13;

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7E;

	localparam logic [15:0] BLANK_CELL = 16'h0F20;
	localparam int          TAB_STOP   = 8;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [15:0]       wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic write_cell;
		logic scroll;
	} cur_flags_t;

endpackage

// ===== src/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Screen cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  tcw_pkg::mem_req_t req,
	output logic [15:0]       rdata
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor
// Next cursor position for one put character, with column wrap and the
// scroll decision on row overflow.
// ----------------------------------------------------------------------------
module tcw_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	localparam int CW = $clog2(COLUMNS + tcw_pkg::TAB_STOP),
	localparam int RW = $clog2(ROWS + 1)
) (
	input  logic [CW-1:0]       col,
	input  logic [RW-1:0]       row,
	input  logic [7:0]          char_code,
	output logic [CW-1:0]       col_next,
	output logic [RW-1:0]       row_next,
	output tcw_pkg::cur_flags_t flags
);

	logic [CW-1:0] col_t;
	logic [RW-1:0] row_t;

	always_comb begin
		col_t = col;
		row_t = row;
		flags = '0;
		case (char_code)
			tcw_pkg::CH_BS: begin
				if (col != '0) begin
					col_t = col - CW'(1);
				end
			end
			tcw_pkg::CH_TAB: begin
				col_t = (col & ~CW'(tcw_pkg::TAB_STOP - 1)) + CW'(tcw_pkg::TAB_STOP);
			end
			tcw_pkg::CH_CR: begin
				col_t = '0;
			end
			tcw_pkg::CH_LF: begin
				col_t = '0;
				row_t = row + RW'(1);
			end
			default: begin
				if (char_code inside {[tcw_pkg::CH_PRINT_LO:tcw_pkg::CH_PRINT_HI]}) begin
					flags.write_cell = 1'b1;
					col_t = col + CW'(1);
				end
			end
		endcase
		// wrap past the last column
		if (col_t >= CW'(COLUMNS)) begin
			col_t = '0;
			row_t = row_t + RW'(1);
		end
		// past the last row
		if (row_t >= RW'(ROWS)) begin
			row_t = RW'(ROWS - 1);
			flags.scroll = 1'b1;
		end
		col_next = col_t;
		row_next = row_t;
	end

endmodule

// ===== src/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine over a screen memory of 16-bit cells.
// ----------------------------------------------------------------------------
// Each input item is a put, clear or read command and gives one result with
// the linear cursor position, the read cell and a scroll flag. After reset a
// clearing pass writes every cell blank, with s_axis_tready low. A put that
// does not scroll is accepted, then writes its cell and updates the cursor;
// a read adds the registered memory read. A clear, and a put that scrolls,
// sweep the whole memory through its single write port, one cell per cycle.
// One item is in work at a time; the result register lets the next item be
// accepted while a result still waits.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // mode, char_code, back_color, fore_color, cell_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata    // cursor_pos, cell_data, scrolled
);

	localparam int CELLS    = COLUMNS * ROWS;
	localparam int AW       = $clog2(CELLS);
	localparam int CW       = $clog2(COLUMNS + tcw_pkg::TAB_STOP);
	localparam int RW       = $clog2(ROWS + 1);
	localparam int MAW      = tcw_pkg::ADDR_W;
	localparam int COPY_END = CELLS - COLUMNS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_RDATA = 3'd2;
	localparam logic [2:0] ST_SWEEP = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [1:0]    mode_q;
	logic [7:0]    ch_q;
	logic [3:0]    bg_q;
	logic [3:0]    fg_q;
	logic [10:0]   idx_q;
	logic [AW-1:0] ctr_q;
	logic          copy_q;
	logic          emit_q;
	logic          scroll_q;
	logic          rd_ok_q;
	logic          sw_vld_s1;
	logic          sw_copy_s1;
	logic [AW-1:0] sw_addr_s1;
	logic          out_valid_q;
	logic [31:0]   out_data_q;

	logic [CW-1:0]       col_n;
	logic [RW-1:0]       row_n;
	tcw_pkg::cur_flags_t flags;
	logic                slot_free;
	logic                emit_exec;
	logic                exec_go;
	logic                load;
	logic                copy_now;
	logic                sweep_last;
	logic                idx_ok;
	logic [AW-1:0]       cell_addr;
	logic [CW-1:0]       pos_col;
	logic [RW-1:0]       pos_row;
	logic [AW-1:0]       pos_full;
	logic [15:0]         out_cell;
	logic                out_scroll;
	tcw_pkg::mem_req_t   mem_req;
	logic [15:0]         rdata;

	tcw_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_cursor (
		.col(col_q),
		.row(row_q),
		.char_code(ch_q),
		.col_next(col_n),
		.row_next(row_n),
		.flags(flags)
	);

	tcw_ram #(
		.DEPTH(CELLS)
	) u_ram (
		.clk(clk),
		.req(mem_req),
		.rdata(rdata)
	);

	always_comb begin
		slot_free  = !out_valid_q || m_axis_tready;
		emit_exec  = (mode_q == tcw_pkg::MODE_PUT && !flags.scroll) ||
			(mode_q != tcw_pkg::MODE_PUT && mode_q != tcw_pkg::MODE_CLEAR &&
			mode_q != tcw_pkg::MODE_READ);
		exec_go    = !emit_exec || slot_free;
		copy_now   = copy_q && (ctr_q < AW'(COPY_END));
		sweep_last = ctr_q == AW'(CELLS - 1);
		idx_ok     = 32'(idx_q) < 32'(CELLS);
		cell_addr  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);

		load       = 1'b0;
		out_cell   = '0;
		out_scroll = 1'b0;
		pos_col    = col_q;
		pos_row    = row_q;
		case (state_q)
			ST_EXEC: begin
				load = emit_exec && slot_free;
				if (mode_q == tcw_pkg::MODE_PUT) begin
					pos_col = col_n;
					pos_row = row_n;
				end
			end
			ST_RDATA: begin
				load = slot_free;
				out_cell = rd_ok_q ? rdata : 16'h0000;
			end
			ST_EMIT: begin
				load = slot_free;
				out_scroll = scroll_q;
			end
			default: begin
				load = 1'b0;
			end
		endcase
		pos_full = AW'(pos_row) * AW'(COLUMNS) + AW'(pos_col);

		mem_req = '0;
		if (sw_vld_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = MAW'(sw_addr_s1);
			mem_req.wdata = sw_copy_s1 ? rdata : tcw_pkg::BLANK_CELL;
		end else if (state_q == ST_EXEC && mode_q == tcw_pkg::MODE_PUT &&
				flags.write_cell && exec_go) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = MAW'(cell_addr);
			mem_req.wdata = {bg_q, fg_q, ch_q};
		end
		if (state_q == ST_SWEEP) begin
			mem_req.re    = copy_now;
			mem_req.raddr = MAW'(ctr_q + AW'(COLUMNS));
		end else if (state_q == ST_EXEC && mode_q == tcw_pkg::MODE_READ) begin
			mem_req.re    = idx_ok;
			mem_req.raddr = MAW'(idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			col_q       <= '0;
			row_q       <= '0;
			ctr_q       <= '0;
			copy_q      <= 1'b0;
			emit_q      <= 1'b0;
			scroll_q    <= 1'b0;
			sw_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sw_vld_s1 <= state_q == ST_SWEEP;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						case (mode_q)
							tcw_pkg::MODE_PUT: begin
								col_q <= col_n;
								row_q <= row_n;
								if (flags.scroll) begin
									state_q  <= ST_SWEEP;
									copy_q   <= 1'b1;
									emit_q   <= 1'b1;
									scroll_q <= 1'b1;
								end else begin
									state_q <= ST_IDLE;
								end
							end
							tcw_pkg::MODE_CLEAR: begin
								col_q    <= '0;
								row_q    <= '0;
								state_q  <= ST_SWEEP;
								copy_q   <= 1'b0;
								emit_q   <= 1'b1;
								scroll_q <= 1'b0;
							end
							tcw_pkg::MODE_READ: begin
								state_q <= ST_RDATA;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RDATA: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (sweep_last) begin
						ctr_q   <= '0;
						state_q <= emit_q ? ST_EMIT : ST_IDLE;
					end else begin
						ctr_q <= ctr_q + AW'(1);
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_q <= s_axis_tdata[1:0];
			ch_q   <= s_axis_tdata[9:2];
			bg_q   <= s_axis_tdata[13:10];
			fg_q   <= s_axis_tdata[17:14];
			idx_q  <= s_axis_tdata[28:18];
		end
		if (state_q == ST_EXEC) begin
			rd_ok_q <= idx_ok;
		end
		sw_addr_s1 <= ctr_q;
		sw_copy_s1 <= copy_now;
		if (load) begin
			out_data_q <= {4'b0000, out_scroll, out_cell, 11'(pos_full)};
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== src/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	localparam int CELLS = COLUMNS * ROWS;

	// result stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while busy");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:28] == 4'h0)
		else $error("result padding not zero");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (CELLS > 2048) || (int'(m_axis_tdata[10:0]) < CELLS))
		else $error("cursor outside screen");

	// a scroll leaves the cursor on the bottom line
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[27] |->
		(CELLS > 2048) || (int'(m_axis_tdata[10:0]) >= (ROWS - 1) * COLUMNS))
		else $error("scroll without cursor on bottom line");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS(ROWS)
) u_tcw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
